>>> hdl/cyk_pkg.sv
// Shared types and constants for the CYK parse tree counter.
package cyk_pkg;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned SYM_W   = 4;
  localparam int unsigned TERM_W  = 7;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_BINARY = 3'd0,
    MODE_UNARY  = 3'd1,
    MODE_SYMBOL = 3'd2,
    MODE_PARSE  = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNARY,
    ST_BINARY,
    ST_DRAIN,
    ST_WRITEBACK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic issue_un;
    logic issue_bin;
    logic wb;
    logic capture;
    logic clear_str;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic overflow;
  } dp_stat_t;

endpackage

>>> hdl/cyk_if.sv
// Request and response channel interfaces of the CYK parse tree counter.
interface cyk_req_if;
  logic                         valid;
  logic                         ready;
  logic [cyk_pkg::MODE_W-1:0]   mode;
  logic [cyk_pkg::SYM_W-1:0]    parent_symbol;
  logic [cyk_pkg::SYM_W-1:0]    left_child;
  logic [cyk_pkg::SYM_W-1:0]    right_child;
  logic [cyk_pkg::TERM_W-1:0]   terminal;

  modport source (output valid, mode, parent_symbol, left_child, right_child, terminal,
                  input ready);
  modport sink (input valid, mode, parent_symbol, left_child, right_child, terminal,
                output ready);
endinterface

interface cyk_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cyk_pkg::COUNT_W-1:0]  tree_count;
  logic [cyk_pkg::STAT_W-1:0]   status;

  modport source (output valid, tree_count, status, input ready);
  modport sink (input valid, tree_count, status, output ready);
endinterface

>>> hdl/cyk_dp.sv
// Datapath: grammar and string stores, chart memory and the multiply-accumulate pipeline.
module cyk_dp import cyk_pkg::*; #(
  parameter int unsigned MAX_LENGTH       = 64,
  parameter int unsigned NONTERMINALS     = 16,
  parameter int unsigned MAX_BINARY_RULES = 512,
  parameter int unsigned MAX_UNARY_RULES  = 128,
  parameter int unsigned TERMINALS        = 128,
  parameter int unsigned LW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1,
  parameter int unsigned NW  = $clog2(NONTERMINALS),
  parameter int unsigned SCW = $clog2(MAX_LENGTH + 1),
  parameter int unsigned BCW = $clog2(MAX_BINARY_RULES + 1),
  parameter int unsigned UCW = $clog2(MAX_UNARY_RULES + 1),
  parameter int unsigned RCW = (BCW > UCW) ? BCW : UCW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [SYM_W-1:0]   parent_i,
  input  logic [SYM_W-1:0]   left_i,
  input  logic [SYM_W-1:0]   right_i,
  input  logic [TERM_W-1:0]  term_i,
  input  logic [LW-1:0]      row_i,
  input  logic [LW-1:0]      len_i,
  input  logic [LW-1:0]      split_i,
  input  logic [RCW-1:0]     rule_i,
  input  logic [NW-1:0]      nt_i,
  output logic [SCW-1:0]     sym_cnt_o,
  output logic [BCW-1:0]     bin_cnt_o,
  output logic [UCW-1:0]     un_cnt_o,
  output dp_stat_t           stat_o,
  output logic [COUNT_W-1:0] result_o
);

  localparam int unsigned BAW = (MAX_BINARY_RULES > 1) ? $clog2(MAX_BINARY_RULES) : 1;
  localparam int unsigned UAW = (MAX_UNARY_RULES > 1) ? $clog2(MAX_UNARY_RULES) : 1;
  localparam int unsigned CAW = 2 * LW + NW;
  localparam int unsigned BRW = 3 * NW;
  localparam int unsigned URW = NW + TERM_W;

  logic [TERM_W-1:0]  sym_mem   [MAX_LENGTH];
  logic [BRW-1:0]     bin_mem   [MAX_BINARY_RULES];
  logic [URW-1:0]     un_mem    [MAX_UNARY_RULES];
  logic [COUNT_W-1:0] chart_mem [2**CAW];

  logic [SCW-1:0] sym_cnt_q;
  logic [BCW-1:0] bin_cnt_q;
  logic [UCW-1:0] un_cnt_q;
  logic           ovf_q;

  logic bin_ok, un_ok;
  logic bin_full, un_full, sym_full;

  assign bin_ok   = (32'(parent_i) < 32'(NONTERMINALS)) && (32'(left_i) < 32'(NONTERMINALS))
                    && (32'(right_i) < 32'(NONTERMINALS));
  assign un_ok    = (32'(parent_i) < 32'(NONTERMINALS)) && (32'(term_i) < 32'(TERMINALS));
  assign bin_full = bin_cnt_q >= BCW'(MAX_BINARY_RULES);
  assign un_full  = un_cnt_q >= UCW'(MAX_UNARY_RULES);
  assign sym_full = sym_cnt_q >= SCW'(MAX_LENGTH);

  // Store fill counts and the sticky overflow flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_cnt_q <= '0;
      bin_cnt_q <= '0;
      un_cnt_q  <= '0;
      ovf_q     <= 1'b0;
    end else if (cmd_i.clear_str) begin
      sym_cnt_q <= '0;
    end else if (cmd_i.load) begin
      unique case (mode_e'(mode_i))
        MODE_BINARY: begin
          if (bin_ok) begin
            if (bin_full) ovf_q <= 1'b1;
            else bin_cnt_q <= bin_cnt_q + BCW'(1);
          end
        end
        MODE_UNARY: begin
          if (un_ok) begin
            if (un_full) ovf_q <= 1'b1;
            else un_cnt_q <= un_cnt_q + UCW'(1);
          end
        end
        MODE_SYMBOL: begin
          if (sym_full) ovf_q <= 1'b1;
          else sym_cnt_q <= sym_cnt_q + SCW'(1);
        end
        MODE_CLEAR: begin
          bin_cnt_q <= '0;
          un_cnt_q  <= '0;
          ovf_q     <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Store writes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (mode_e'(mode_i) == MODE_BINARY && bin_ok && !bin_full) begin
        bin_mem[bin_cnt_q[BAW-1:0]] <= {NW'(parent_i), NW'(left_i), NW'(right_i)};
      end
      if (mode_e'(mode_i) == MODE_UNARY && un_ok && !un_full) begin
        un_mem[un_cnt_q[UAW-1:0]] <= {NW'(parent_i), term_i};
      end
      if (mode_e'(mode_i) == MODE_SYMBOL && !sym_full) begin
        sym_mem[sym_cnt_q[LW-1:0]] <= term_i;
      end
    end
  end

  // Pipeline: rule fetch, chart fetch, multiply, accumulate.
  logic               v1_q, v2_q, v3_q;
  logic               un1_q, un2_q;
  logic [BRW-1:0]     bin_rd_q;
  logic [URW-1:0]     un_rd_q;
  logic [TERM_W-1:0]  sym_rd_q;
  logic [LW-1:0]      lc_st_q, lc_len_q, rc_st_q, rc_len_q;
  logic [COUNT_W-1:0] lc_q, rc_q, prod_q;
  logic               match_q;
  logic [NW-1:0]      par2_q, par3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue_un | cmd_i.issue_bin;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_rd_q <= bin_mem[rule_i[BAW-1:0]];
    un_rd_q  <= un_mem[rule_i[UAW-1:0]];
    sym_rd_q <= sym_mem[row_i];
    un1_q    <= cmd_i.issue_un;
    lc_st_q  <= row_i;
    lc_len_q <= split_i;
    rc_st_q  <= LW'({1'b0, row_i} + {1'b0, split_i} + (LW + 1)'(1));
    rc_len_q <= len_i - split_i - LW'(1);

    lc_q    <= chart_mem[{lc_st_q, lc_len_q, bin_rd_q[NW +: NW]}];
    rc_q    <= chart_mem[{rc_st_q, rc_len_q, bin_rd_q[0 +: NW]}];
    match_q <= un_rd_q[TERM_W-1:0] == sym_rd_q;
    par2_q  <= un1_q ? un_rd_q[TERM_W +: NW] : bin_rd_q[2*NW +: NW];
    un2_q   <= un1_q;

    prod_q <= un2_q ? COUNT_W'(match_q) : lc_q * rc_q;
    par3_q <= par2_q;
  end

  // Per-cell accumulators, one per nonterminal; writeback empties them.
  logic [COUNT_W-1:0] acc_q [NONTERMINALS];
  logic [NW-1:0]      acc_idx;
  logic [COUNT_W-1:0] acc_rd;

  assign acc_idx = cmd_i.wb ? nt_i : par3_q;
  assign acc_rd  = acc_q[acc_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NONTERMINALS; i++) acc_q[i] <= '0;
    end else if (cmd_i.wb) begin
      acc_q[acc_idx] <= '0;
    end else if (v3_q) begin
      acc_q[acc_idx] <= acc_rd + prod_q;
    end
  end

  logic [COUNT_W-1:0] result_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) chart_mem[{row_i, len_i, nt_i}] <= acc_rd;
    if (cmd_i.wb && cmd_i.capture) result_q <= acc_rd;
  end

  assign sym_cnt_o       = sym_cnt_q;
  assign bin_cnt_o       = bin_cnt_q;
  assign un_cnt_o        = un_cnt_q;
  assign stat_o.busy     = v1_q | v2_q | v3_q;
  assign stat_o.overflow = ovf_q;
  assign result_o        = result_q;

endmodule

>>> hdl/cyk_ctrl.sv
// Controller: request handshake, chart traversal sequencer and response register.
module cyk_ctrl import cyk_pkg::*; #(
  parameter int unsigned MAX_LENGTH   = 64,
  parameter int unsigned NONTERMINALS = 16,
  parameter int unsigned LW  = 6,
  parameter int unsigned NW  = 4,
  parameter int unsigned SCW = 7,
  parameter int unsigned BCW = 10,
  parameter int unsigned UCW = 8,
  parameter int unsigned RCW = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic [MODE_W-1:0]  req_mode_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output logic [COUNT_W-1:0] rsp_count_o,
  output logic [STAT_W-1:0]  rsp_status_o,
  output dp_cmd_t            cmd_o,
  input  dp_stat_t           stat_i,
  input  logic [SCW-1:0]     sym_cnt_i,
  input  logic [BCW-1:0]     bin_cnt_i,
  input  logic [UCW-1:0]     un_cnt_i,
  input  logic [COUNT_W-1:0] result_i,
  output logic [LW-1:0]      row_o,
  output logic [LW-1:0]      len_o,
  output logic [LW-1:0]      split_o,
  output logic [RCW-1:0]     rule_o,
  output logic [NW-1:0]      nt_o
);

  state_e state_q, state_d;

  logic [LW-1:0]  row_q, len_q, split_q;
  logic [RCW-1:0] rule_q;
  logic [NW-1:0]  nt_q;
  logic           empty_q;
  logic           out_valid_q;
  logic [COUNT_W-1:0] out_count_q;
  status_e        out_status_q;

  logic parse_req, slot_free;
  logic un_last, bin_last, split_last, nt_last, final_cell, more_rows;

  assign parse_req  = (state_q == ST_IDLE) && req_valid_i && (mode_e'(req_mode_i) == MODE_PARSE);
  assign slot_free  = !out_valid_q || rsp_ready_i;
  assign un_last    = (rule_q + RCW'(1)) == RCW'(un_cnt_i);
  assign bin_last   = (rule_q + RCW'(1)) == RCW'(bin_cnt_i);
  assign split_last = split_q == (len_q - LW'(1));
  assign nt_last    = nt_q == NW'(NONTERMINALS - 1);
  assign final_cell = (row_q == '0) && ((LW + 2)'(len_q) + (LW + 2)'(1) == (LW + 2)'(sym_cnt_i));
  // Another start position exists for the current span length.
  assign more_rows  = (LW + 2)'(row_q) + (LW + 2)'(len_q) + (LW + 2)'(2)
                      <= (LW + 2)'(sym_cnt_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (parse_req) begin
          if (sym_cnt_i == '0) state_d = ST_EMIT;
          else if (un_cnt_i == '0) state_d = ST_DRAIN;
          else state_d = ST_UNARY;
        end
      end
      ST_UNARY:  if (un_last) state_d = ST_DRAIN;
      ST_BINARY: if (bin_last && split_last) state_d = ST_DRAIN;
      ST_DRAIN:  if (!stat_i.busy) state_d = ST_WRITEBACK;
      ST_WRITEBACK: begin
        if (nt_last) begin
          if (final_cell) state_d = ST_EMIT;
          else if (more_rows && len_q == '0) state_d = (un_cnt_i == '0) ? ST_DRAIN : ST_UNARY;
          else state_d = (bin_cnt_i == '0) ? ST_DRAIN : ST_BINARY;
        end
      end
      ST_EMIT: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == ST_IDLE) && req_valid_i
                      && (mode_e'(req_mode_i) != MODE_PARSE);
    cmd_o.issue_un  = state_q == ST_UNARY;
    cmd_o.issue_bin = state_q == ST_BINARY;
    cmd_o.wb        = state_q == ST_WRITEBACK;
    cmd_o.capture   = (state_q == ST_WRITEBACK) && (nt_q == '0) && final_cell;
    cmd_o.clear_str = (state_q == ST_EMIT) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      len_q   <= '0;
      split_q <= '0;
      rule_q  <= '0;
      nt_q    <= '0;
      empty_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (parse_req) begin
            row_q   <= '0;
            len_q   <= '0;
            split_q <= '0;
            rule_q  <= '0;
            empty_q <= sym_cnt_i == '0;
          end
        end
        ST_UNARY: rule_q <= un_last ? '0 : rule_q + RCW'(1);
        ST_BINARY: begin
          if (bin_last) begin
            rule_q  <= '0;
            split_q <= split_last ? '0 : split_q + LW'(1);
          end else begin
            rule_q <= rule_q + RCW'(1);
          end
        end
        ST_DRAIN: nt_q <= '0;
        ST_WRITEBACK: begin
          nt_q <= nt_q + NW'(1);
          if (nt_last && !final_cell) begin
            if (more_rows) begin
              row_q <= row_q + LW'(1);
            end else begin
              row_q <= '0;
              len_q <= len_q + LW'(1);
            end
          end
        end
        ST_EMIT: ;
        default: ;
      endcase
    end
  end

  // Response register: a finished result waits here while loads continue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && slot_free) begin
      out_count_q <= empty_q ? '0 : result_i;
      if (empty_q) out_status_q <= STATUS_EMPTY;
      else if (stat_i.overflow) out_status_q <= STATUS_OVERFLOW;
      else out_status_q <= STATUS_OK;
    end
  end

  assign req_ready_o  = state_q == ST_IDLE;
  assign rsp_valid_o  = out_valid_q;
  assign rsp_count_o  = out_count_q;
  assign rsp_status_o = out_status_q;
  assign row_o        = row_q;
  assign len_o        = len_q;
  assign split_o      = split_q;
  assign rule_o       = rule_q;
  assign nt_o         = nt_q;

  // Only one kind of rule enters the pipeline at a time.
  a_issue_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.issue_un && cmd_o.issue_bin))
    else $error("unary and binary issue together");

  // A cell is written back only after all its products have been summed.
  a_wb_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wb |-> !stat_i.busy)
    else $error("writeback with products in flight");

  // A parse request blocks further requests until its result is queued.
  a_parse_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    parse_req |=> !req_ready_o)
    else $error("request accepted during a parse");

  // Loads never reach the stores while the chart is being filled.
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.busy |-> !cmd_o.load)
    else $error("store load during chart fill");

endmodule

>>> hdl/cyk_parse_tree_counter.sv
// Top level of the CYK parse tree counter: controller and datapath.
//
//   channel  direction  payload
//   req_i    in         mode, parent_symbol, left_child, right_child, terminal
//   rsp_o    out        tree_count, status (one response per parse request)
//
// Rule, symbol and clear requests are taken while the controller is idle.
// A parse request steps, per chart cell, through each unary rule (span 1) or each
// binary rule and split point, drains the pipeline, and writes back all NONTERMINALS
// accumulators; the single multiply-accumulate path on the chart's two read ports
// sets this sequence. An empty string goes straight to the response register.
// Reset leaves the chart uncleared: every cell is rewritten before it is read.
// A pending response does not block loads; a parse waits for the response slot.
module cyk_parse_tree_counter import cyk_pkg::*; #(
  parameter int unsigned MAX_LENGTH       = 64,
  parameter int unsigned NONTERMINALS     = 16,
  parameter int unsigned MAX_BINARY_RULES = 512,
  parameter int unsigned MAX_UNARY_RULES  = 128,
  parameter int unsigned TERMINALS        = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cyk_req_if.sink   req_i,
  cyk_rsp_if.source rsp_o
);

  localparam int unsigned LW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned NW  = $clog2(NONTERMINALS);
  localparam int unsigned SCW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned BCW = $clog2(MAX_BINARY_RULES + 1);
  localparam int unsigned UCW = $clog2(MAX_UNARY_RULES + 1);
  localparam int unsigned RCW = (BCW > UCW) ? BCW : UCW;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [SCW-1:0]     sym_cnt;
  logic [BCW-1:0]     bin_cnt;
  logic [UCW-1:0]     un_cnt;
  logic [COUNT_W-1:0] result;
  logic [LW-1:0]      row, len, split;
  logic [RCW-1:0]     rule;
  logic [NW-1:0]      nt;

  cyk_ctrl #(
    .MAX_LENGTH   (MAX_LENGTH),
    .NONTERMINALS (NONTERMINALS),
    .LW (LW), .NW (NW), .SCW (SCW), .BCW (BCW), .UCW (UCW), .RCW (RCW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_mode_i   (req_i.mode),
    .req_ready_o  (req_i.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_count_o  (rsp_o.tree_count),
    .rsp_status_o (rsp_o.status),
    .cmd_o        (cmd),
    .stat_i       (stat),
    .sym_cnt_i    (sym_cnt),
    .bin_cnt_i    (bin_cnt),
    .un_cnt_i     (un_cnt),
    .result_i     (result),
    .row_o        (row),
    .len_o        (len),
    .split_o      (split),
    .rule_o       (rule),
    .nt_o         (nt)
  );

  cyk_dp #(
    .MAX_LENGTH       (MAX_LENGTH),
    .NONTERMINALS     (NONTERMINALS),
    .MAX_BINARY_RULES (MAX_BINARY_RULES),
    .MAX_UNARY_RULES  (MAX_UNARY_RULES),
    .TERMINALS        (TERMINALS),
    .LW (LW), .NW (NW), .SCW (SCW), .BCW (BCW), .UCW (UCW), .RCW (RCW)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .mode_i    (req_i.mode),
    .parent_i  (req_i.parent_symbol),
    .left_i    (req_i.left_child),
    .right_i   (req_i.right_child),
    .term_i    (req_i.terminal),
    .row_i     (row),
    .len_i     (len),
    .split_i   (split),
    .rule_i    (rule),
    .nt_i      (nt),
    .sym_cnt_o (sym_cnt),
    .bin_cnt_o (bin_cnt),
    .un_cnt_o  (un_cnt),
    .stat_o    (stat),
    .result_o  (result)
  );

endmodule

>>> sim/cyk_scoreboard.sv
// Checker for the CYK parse tree counter: predicts parse responses and compares them.
`timescale 1ns / 1ps

module cyk_scoreboard import cyk_pkg::*; #(
  parameter int unsigned MAX_LENGTH       = 64,
  parameter int unsigned NONTERMINALS     = 16,
  parameter int unsigned MAX_BINARY_RULES = 512,
  parameter int unsigned MAX_UNARY_RULES  = 128,
  parameter int unsigned TERMINALS        = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  cyk_req_if   req,
  cyk_rsp_if   rsp,
  output int   errors_o,
  output int   pending_o
);

  typedef struct packed {
    logic [COUNT_W-1:0] tree_count;
    status_e            status;
  } parse_result_t;

  logic [TERM_W-1:0]  text [MAX_LENGTH];
  int unsigned        text_len;
  logic [SYM_W-1:0]   bin_par [MAX_BINARY_RULES];
  logic [SYM_W-1:0]   bin_lft [MAX_BINARY_RULES];
  logic [SYM_W-1:0]   bin_rgt [MAX_BINARY_RULES];
  int unsigned        bin_cnt;
  logic [SYM_W-1:0]   un_par [MAX_UNARY_RULES];
  logic [TERM_W-1:0]  un_term [MAX_UNARY_RULES];
  int unsigned        un_cnt;
  logic               dropped;
  logic [COUNT_W-1:0] chart [MAX_LENGTH][MAX_LENGTH][NONTERMINALS];
  parse_result_t      expected_parses [$];

  assign pending_o = expected_parses.size();

  // Fills the chart for the current string and returns the count for symbol 0.
  function automatic logic [COUNT_W-1:0] count_trees();
    int unsigned n;
    logic [COUNT_W-1:0] total;
    n = text_len;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        for (int s = 0; s < NONTERMINALS; s++) chart[i][j][s] = '0;
    for (int i = 0; i < n; i++)
      for (int r = 0; r < un_cnt; r++)
        if (un_term[r] == text[i]) chart[i][0][un_par[r]] += 1;
    for (int len = 2; len <= n; len++)
      for (int st = 0; st + len <= n; st++)
        for (int k = 1; k < len; k++)
          for (int r = 0; r < bin_cnt; r++)
            chart[st][len-1][bin_par[r]] += chart[st][k-1][bin_lft[r]] *
                                            chart[st+k][len-k-1][bin_rgt[r]];
    total = chart[0][n-1][0];
    return total;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t got, want;
    if (!rst_ni) begin
      text_len = 0;
      bin_cnt  = 0;
      un_cnt   = 0;
      dropped  = 1'b0;
      errors_o = 0;
      expected_parses.delete();
    end else begin
      if (req.valid && req.ready) begin
        case (req.mode)
          MODE_BINARY: begin
            if (int'(req.parent_symbol) < NONTERMINALS && int'(req.left_child) < NONTERMINALS
                && int'(req.right_child) < NONTERMINALS) begin
              if (bin_cnt >= MAX_BINARY_RULES) dropped = 1'b1;
              else begin
                bin_par[bin_cnt] = req.parent_symbol;
                bin_lft[bin_cnt] = req.left_child;
                bin_rgt[bin_cnt] = req.right_child;
                bin_cnt = bin_cnt + 1;
              end
            end
          end
          MODE_UNARY: begin
            if (int'(req.parent_symbol) < NONTERMINALS && int'(req.terminal) < TERMINALS) begin
              if (un_cnt >= MAX_UNARY_RULES) dropped = 1'b1;
              else begin
                un_par[un_cnt]  = req.parent_symbol;
                un_term[un_cnt] = req.terminal;
                un_cnt = un_cnt + 1;
              end
            end
          end
          MODE_SYMBOL: begin
            if (text_len >= MAX_LENGTH) dropped = 1'b1;
            else begin
              text[text_len] = req.terminal;
              text_len = text_len + 1;
            end
          end
          MODE_PARSE: begin
            if (text_len == 0) begin
              want.tree_count = '0;
              want.status     = STATUS_EMPTY;
            end else begin
              want.tree_count = count_trees();
              want.status     = dropped ? STATUS_OVERFLOW : STATUS_OK;
            end
            expected_parses.push_back(want);
            text_len = 0;
          end
          MODE_CLEAR: begin
            bin_cnt = 0;
            un_cnt  = 0;
            dropped = 1'b0;
          end
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        got.tree_count = rsp.tree_count;
        got.status     = status_e'(rsp.status);
        if (expected_parses.size() == 0) begin
          $display("%0t: response with nothing expected: count %0d status %0d",
                   $time, got.tree_count, got.status);
          errors_o = errors_o + 1;
        end else begin
          want = expected_parses.pop_front();
          if (got.tree_count !== want.tree_count) begin
            $display("%0t: tree_count expected %0d actual %0d",
                     $time, want.tree_count, got.tree_count);
            errors_o = errors_o + 1;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors_o = errors_o + 1;
          end
        end
      end
    end
  end

endmodule

>>> sim/tb_cyk_parse_tree_counter.sv
// Testbench top for the CYK parse tree counter: stimulus, response stalls and verdict.
`timescale 1ns / 1ps

module tb_cyk_parse_tree_counter;
  import cyk_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned RANDOM_ITEMS = 900;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   cycles;
  int   sent;
  int   grammar_size;
  bit   no_gaps;
  bit   hold_rsp;

  cyk_req_if req ();
  cyk_rsp_if rsp ();

  cyk_parse_tree_counter dut (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  cyk_scoreboard sb (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one request and returns after it is accepted; valid stays high.
  task automatic send(int m, int p, int l, int r, int t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid         = 1'b1;
    req.mode          = MODE_W'(m);
    req.parent_symbol = SYM_W'(p);
    req.left_child    = SYM_W'(l);
    req.right_child   = SYM_W'(r);
    req.terminal      = TERM_W'(t);
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic binary_rule(int p, int l, int r);
    send(MODE_BINARY, p, l, r, $urandom);
    grammar_size++;
  endtask

  task automatic unary_rule(int p, int t);
    send(MODE_UNARY, p, $urandom, $urandom, t);
    grammar_size++;
  endtask

  task automatic symbol(int t);
    send(MODE_SYMBOL, $urandom, $urandom, $urandom, t);
  endtask

  task automatic parse();
    send(MODE_PARSE, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic clear_grammar();
    send(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
    grammar_size = 0;
  endtask

  // Receiver: random stalls, bursts with none, and one long hold-off on request.
  initial begin
    int gap;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp.ready = 1'b0;
        repeat (3000) @(negedge clk_i);
        hold_rsp = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        rsp.ready = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else rsp.ready = 1'b1;
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int alphabet, nts, len;
    req.valid = 1'b0;
    req.mode = MODE_CLEAR;
    req.parent_symbol = '0;
    req.left_child = '0;
    req.right_child = '0;
    req.terminal = '0;
    rst_ni = 1'b0;
    no_gaps = 1'b0;
    hold_rsp = 1'b0;
    sent = 0;
    grammar_size = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty string, then a small grammar with extreme field values.
    parse();
    unary_rule(1, 0);
    unary_rule(15, 127);
    unary_rule(0, 127);
    binary_rule(0, 1, 15);
    binary_rule(0, 1, 15);
    binary_rule(15, 15, 15);
    symbol(0);
    symbol(127);
    parse();
    for (int m = int'(MODE_CLEAR) + 1; m < (1 << MODE_W); m++)
      send(m, $urandom, $urandom, $urandom, $urandom);
    symbol(127);
    parse();
    // The string survives a grammar clear.
    symbol(0);
    clear_grammar();
    unary_rule(0, 0);
    parse();

    // Full-length string under an ambiguous grammar, then one symbol too many.
    clear_grammar();
    unary_rule(0, 5);
    binary_rule(0, 0, 0);
    for (int i = 0; i < 65; i++) symbol(5);
    parse();
    // Sticky overflow: the next parse still reports it.
    symbol(5);
    parse();

    // Overfill both rule stores.
    clear_grammar();
    for (int i = 0; i < 513; i++) binary_rule($urandom_range(0, 3), 1, $urandom_range(0, 1));
    for (int i = 0; i < 129; i++) unary_rule($urandom_range(0, 1), $urandom_range(0, 1));
    symbol(0);
    symbol(1);
    parse();
    parse();
    clear_grammar();

    // Long response stall while parses keep coming, so the input backs up.
    hold_rsp = 1'b1;
    unary_rule(0, 2);
    binary_rule(0, 0, 0);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) symbol(2);
      parse();
    end
    clear_grammar();

    // Random sentences over mostly small alphabets and few nonterminals.
    while (sent < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      if (grammar_size > 28 || $urandom_range(0, 9) == 0) clear_grammar();
      alphabet = ($urandom_range(0, 5) == 0) ? 127 : $urandom_range(1, 3);
      nts = ($urandom_range(0, 5) == 0) ? 15 : $urandom_range(0, 3);
      repeat ($urandom_range(0, 6)) binary_rule($urandom_range(0, nts),
                                                $urandom_range(0, nts),
                                                $urandom_range(0, nts));
      repeat ($urandom_range(0, 4)) unary_rule($urandom_range(0, nts),
                                               $urandom_range(0, alphabet));
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0)
          send($urandom_range(int'(MODE_CLEAR) + 1, (1 << MODE_W) - 1),
               $urandom, $urandom, $urandom, $urandom);
        symbol($urandom_range(0, alphabet));
      end
      parse();
    end

    req.valid = 1'b0;
    no_gaps = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
